/* sv/sact_pkg.sv */
package sact_pkg;

	localparam int MAX_SETS  = 4096;
	localparam int MAX_WAYS  = 4;
	localparam int MAX_WORDS = 16;

	localparam int ADDR_W  = 31;
	localparam int CYC_W   = 48;
	localparam int CNT_W   = 32;
	localparam int ACC_W   = 7;
	localparam int WAY_W   = 2;
	localparam int SET_W   = $clog2(MAX_SETS);
	localparam int WAYS_W  = 3;
	localparam int SETS_W  = 13;
	localparam int WORDS_W = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 13;
	localparam int STEP_W  = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_WAYS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORDS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LRU   = 3'd3;

	localparam logic [ACC_W-1:0] COST_HIT  = 7'd5;
	localparam logic [ACC_W-1:0] COST_MEM  = 7'd60;
	localparam logic [ACC_W-1:0] COST_FILL = 7'd5;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] word_addr;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [WAY_W-1:0]  way;
		logic              evict_valid;
		logic              evict_dirty;
		logic [ADDR_W-1:0] evicted_block;
		logic [ACC_W-1:0]  access_cycles;
		logic [CYC_W-1:0]  total_cycles;
		logic [CNT_W-1:0]  total_misses;
		logic [CNT_W-1:0]  read_misses;
		logic [CNT_W-1:0]  dirty_evictions;
	} rsp_t;

	typedef struct packed {
		logic              valid;
		logic              dirty;
		logic [ADDR_W-1:0] block;
		logic [CYC_W-1:0]  stamp;
	} line_t;

	typedef line_t [MAX_WAYS-1:0] row_t;

endpackage

/* sv/set_assoc_cache_tag_policy.sv */
// channel   signals                               handshake
// request   start, busy, req                      taken when start & !busy
// result    done, result                          one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_index/data  taken when valid & ready
//
// After acceptance busy stays high through the one shared divider (block number,
// then set index), one tag row read, a scan of each way in use, then the hit
// state on a hit, the miss and fill states on a clean miss, or the miss, dirty
// and fill states on a dirty miss, with a further divider pass before the miss
// state on a random-policy miss. done follows in the cycle after the last busy
// cycle. After reset a clearing pass writes one set row a cycle over all
// MAX_SETS rows, with busy high. Config is taken only while idle with start low.
module set_assoc_cache_tag_policy (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  sact_pkg::req_t                   req,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sact_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sact_pkg::CFG_DAT_W-1:0]   cfg_data,
	output logic                             done,
	output sact_pkg::rsp_t                   result
);
	import sact_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DIV_BLK, S_DIV_SET, S_RD, S_SCAN, S_DIV_RND,
		S_HIT, S_MISS, S_DIRTY, S_FILL
	} state_t;

	state_t state_q;

	logic [WAYS_W-1:0]  ways_q;
	logic [SETS_W-1:0]  sets_q;
	logic [WORDS_W-1:0] words_q;
	logic               lru_q;

	logic [WAYS_W-1:0]  ways_c;
	logic [SETS_W-1:0]  sets_c;
	logic [WORDS_W-1:0] words_c;

	// shared divider
	logic [ADDR_W-1:0] dvd_q;
	logic [SETS_W-1:0] dvs_q;
	logic [SETS_W-1:0] rem_q;
	logic [ADDR_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic [SETS_W:0]   rem_sh;
	logic              ge;
	logic [SETS_W-1:0] rem_nx;
	logic [ADDR_W-1:0] quo_nx;
	logic              div_last;

	logic              wr_q;
	logic [ADDR_W-1:0] blk_q;
	logic [SET_W-1:0]  set_q;
	logic [SET_W-1:0]  clr_q;
	logic [WAY_W-1:0]  w_q;
	logic              hit_q;
	logic [WAY_W-1:0]  hway_q;
	logic [CYC_W-1:0]  min_q;
	logic [WAY_W-1:0]  lru_w_q;
	logic [WAY_W-1:0]  vic_q;
	logic              ev_valid_q;
	logic              ev_dirty_q;
	logic [ADDR_W-1:0] ev_block_q;
	logic [15:0]       lfsr_q;
	logic [15:0]       lfsr_nx;

	logic [CYC_W-1:0]  cyc_q;
	logic [CNT_W-1:0]  miss_q;
	logic [CNT_W-1:0]  rmiss_q;
	logic [CNT_W-1:0]  devict_q;

	row_t              mem [MAX_SETS];
	row_t              row_q;
	row_t              wr_row;
	logic              mem_we;
	logic [SET_W-1:0]  mem_wa;
	line_t             ln;
	line_t             vl;
	logic              hit_now;
	logic [WAY_W-1:0]  hway_now;
	logic              less_now;
	logic [WAY_W-1:0]  lru_now;
	logic              scan_last;
	logic [CYC_W-1:0]  cyc_add;
	logic [ACC_W-1:0]  add_n;

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	assign ways_c  = (ways_q == '0) ? WAYS_W'(1) :
	                 (ways_q > WAYS_W'(MAX_WAYS)) ? WAYS_W'(MAX_WAYS) : ways_q;
	assign sets_c  = (sets_q == '0) ? SETS_W'(1) :
	                 (sets_q > SETS_W'(MAX_SETS)) ? SETS_W'(MAX_SETS) : sets_q;
	assign words_c = (words_q == '0) ? WORDS_W'(1) :
	                 (words_q > WORDS_W'(MAX_WORDS)) ? WORDS_W'(MAX_WORDS) : words_q;

	assign rem_sh   = {rem_q, dvd_q[ADDR_W-1]};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign rem_nx   = ge ? SETS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[SETS_W-1:0];
	assign quo_nx   = {quo_q[ADDR_W-2:0], ge};
	assign div_last = step_q == STEP_W'(ADDR_W - 1);

	assign lfsr_nx = lfsr_q[0] ? ({1'b0, lfsr_q[15:1]} ^ LFSR_TAPS) : {1'b0, lfsr_q[15:1]};

	assign ln        = row_q[w_q];
	assign hit_now   = hit_q || (ln.valid && ln.block == blk_q);
	assign hway_now  = hit_q ? hway_q : w_q;
	assign less_now  = (w_q == '0) || (ln.stamp < min_q);
	assign lru_now   = less_now ? w_q : lru_w_q;
	assign scan_last = {1'b0, w_q} == (ways_c - WAYS_W'(1));
	assign vl        = row_q[vic_q];

	always_comb begin
		case (state_q)
			S_HIT:   add_n = COST_HIT;
			S_FILL:  add_n = COST_FILL;
			default: add_n = COST_MEM;
		endcase
	end

	always_comb begin
		logic [CYC_W:0] s;
		s = {1'b0, cyc_q} + (CYC_W + 1)'(add_n);
		cyc_add = s[CYC_W] ? {CYC_W{1'b1}} : s[CYC_W-1:0];
	end

	always_comb begin
		wr_row = row_q;
		mem_we = 1'b0;
		mem_wa = set_q;
		case (state_q)
			S_CLR: begin
				wr_row = '0;
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			S_HIT: begin
				wr_row[hway_q].stamp = cyc_add;
				wr_row[hway_q].dirty = row_q[hway_q].dirty | wr_q;
				mem_we = 1'b1;
			end
			S_FILL: begin
				wr_row[vic_q].valid = 1'b1;
				wr_row[vic_q].dirty = wr_q;
				wr_row[vic_q].block = blk_q;
				wr_row[vic_q].stamp = cyc_q;
				mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= wr_row;
		end
		if (state_q == S_RD) begin
			row_q <= mem[set_q];
		end
	end

	assign cfg_ready = (state_q == S_IDLE) && !start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q  <= WAYS_W'(2);
			sets_q  <= SETS_W'(2048);
			words_q <= WORDS_W'(2);
			lru_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WAYS:  ways_q  <= cfg_data[WAYS_W-1:0];
				CFG_SETS:  sets_q  <= cfg_data[SETS_W-1:0];
				CFG_WORDS: words_q <= cfg_data[WORDS_W-1:0];
				CFG_LRU:   lru_q   <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			cyc_q    <= '0;
			miss_q   <= '0;
			rmiss_q  <= '0;
			devict_q <= '0;
			lfsr_q   <= LFSR_SEED;
			done     <= 1'b0;
		end else begin
			done <= (state_q == S_HIT) || (state_q == S_FILL);
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(MAX_SETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						wr_q   <= req.func;
						dvd_q  <= req.word_addr;
						dvs_q  <= SETS_W'(words_c);
						rem_q  <= '0;
						step_q <= '0;
						state_q <= S_DIV_BLK;
					end
				end
				S_DIV_BLK: begin
					if (div_last) begin
						blk_q  <= quo_nx;
						dvd_q  <= quo_nx;
						dvs_q  <= sets_c;
						rem_q  <= '0;
						step_q <= '0;
						state_q <= S_DIV_SET;
					end else begin
						dvd_q  <= {dvd_q[ADDR_W-2:0], 1'b0};
						rem_q  <= rem_nx;
						quo_q  <= quo_nx;
						step_q <= step_q + 1'b1;
					end
				end
				S_DIV_SET: begin
					if (div_last) begin
						set_q   <= rem_nx[SET_W-1:0];
						state_q <= S_RD;
					end else begin
						dvd_q  <= {dvd_q[ADDR_W-2:0], 1'b0};
						rem_q  <= rem_nx;
						quo_q  <= quo_nx;
						step_q <= step_q + 1'b1;
					end
				end
				S_RD: begin
					w_q     <= '0;
					hit_q   <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					hit_q   <= hit_now;
					hway_q  <= hway_now;
					lru_w_q <= lru_now;
					if (less_now) begin
						min_q <= ln.stamp;
					end
					w_q <= w_q + 1'b1;
					if (scan_last) begin
						if (hit_now) begin
							state_q <= S_HIT;
						end else if (lru_q) begin
							vic_q   <= lru_now;
							state_q <= S_MISS;
						end else begin
							lfsr_q  <= lfsr_nx;
							dvd_q   <= ADDR_W'(lfsr_nx);
							dvs_q   <= SETS_W'(ways_c);
							rem_q   <= '0;
							step_q  <= '0;
							state_q <= S_DIV_RND;
						end
					end
				end
				S_DIV_RND: begin
					if (div_last) begin
						vic_q   <= rem_nx[WAY_W-1:0];
						state_q <= S_MISS;
					end else begin
						dvd_q  <= {dvd_q[ADDR_W-2:0], 1'b0};
						rem_q  <= rem_nx;
						quo_q  <= quo_nx;
						step_q <= step_q + 1'b1;
					end
				end
				S_HIT: begin
					cyc_q <= cyc_add;
					result.hit             <= 1'b1;
					result.way             <= hway_q;
					result.evict_valid     <= 1'b0;
					result.evict_dirty     <= 1'b0;
					result.evicted_block   <= '0;
					result.access_cycles   <= COST_HIT;
					result.total_cycles    <= cyc_add;
					result.total_misses    <= miss_q;
					result.read_misses     <= rmiss_q;
					result.dirty_evictions <= devict_q;
					state_q <= S_IDLE;
				end
				S_MISS: begin
					cyc_q  <= cyc_add;
					miss_q <= inc_sat(miss_q);
					if (!wr_q) begin
						rmiss_q <= inc_sat(rmiss_q);
					end
					ev_valid_q <= vl.valid;
					ev_dirty_q <= vl.valid && vl.dirty;
					ev_block_q <= vl.valid ? vl.block : '0;
					state_q <= (vl.valid && vl.dirty) ? S_DIRTY : S_FILL;
				end
				S_DIRTY: begin
					cyc_q    <= cyc_add;
					devict_q <= inc_sat(devict_q);
					state_q  <= S_FILL;
				end
				S_FILL: begin
					cyc_q <= cyc_add;
					result.hit             <= 1'b0;
					result.way             <= vic_q;
					result.evict_valid     <= ev_valid_q;
					result.evict_dirty     <= ev_dirty_q;
					result.evicted_block   <= ev_block_q;
					result.access_cycles   <= ev_dirty_q ? ACC_W'(COST_MEM + COST_MEM + COST_FILL)
					                                     : ACC_W'(COST_MEM + COST_FILL);
					result.total_cycles    <= cyc_add;
					result.total_misses    <= miss_q;
					result.read_misses     <= rmiss_q;
					result.dirty_evictions <= devict_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
	import sact_pkg::*;

	localparam int LINES = MAX_SETS * MAX_WAYS;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [CYC_W-1:0] CYC_SAT = '1;
	localparam logic [CNT_W-1:0] CNT_SAT = '1;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic done;
	rsp_t result;

	set_assoc_cache_tag_policy dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow cache
	logic [WAYS_W-1:0] m_ways;
	logic [SETS_W-1:0] m_sets;
	logic [WORDS_W-1:0] m_words;
	logic m_lru;
	logic m_valid[LINES];
	logic m_dirty[LINES];
	logic [ADDR_W-1:0] m_block[LINES];
	logic [CYC_W-1:0] m_stamp[LINES];
	logic [CYC_W-1:0] m_cycles;
	logic [CNT_W-1:0] m_misses, m_rd_misses, m_dirty_ev;
	logic [15:0] m_lfsr;

	rsp_t pending_rsp[$];
	int failures = 0;
	int idle_cycles = 0;

	function automatic logic [CYC_W-1:0] add_cyc(logic [CYC_W-1:0] c, int n);
		logic [CYC_W:0] s;
		s = {1'b0, c} + n;
		return s[CYC_W] ? CYC_SAT : s[CYC_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
		return (v == CNT_SAT) ? CNT_SAT : v + 1'b1;
	endfunction

	task automatic shadow_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		case (idx)
			CFG_WAYS: m_ways = d[WAYS_W-1:0];
			CFG_SETS: m_sets = d[SETS_W-1:0];
			CFG_WORDS: m_words = d[WORDS_W-1:0];
			CFG_LRU: m_lru = d[0];
			default: ;
		endcase
	endtask

	task automatic shadow_reset();
		m_ways = 3'd2; m_sets = 13'd2048; m_words = 5'd2; m_lru = 1'b1;
		for (int i = 0; i < LINES; i++) begin
			m_valid[i] = 1'b0; m_dirty[i] = 1'b0; m_block[i] = '0; m_stamp[i] = '0;
		end
		m_cycles = '0; m_misses = '0; m_rd_misses = '0; m_dirty_ev = '0;
		m_lfsr = LFSR_SEED;
	endtask

	function automatic rsp_t cache_access(req_t r);
		rsp_t o;
		int ways, sets, wpb, base, v, idx;
		logic [ADDR_W-1:0] blk;
		logic lsb;
		ways = (m_ways < 1) ? 1 : (m_ways > MAX_WAYS) ? MAX_WAYS : m_ways;
		sets = (m_sets < 1) ? 1 : (m_sets > MAX_SETS) ? MAX_SETS : m_sets;
		wpb = (m_words < 1) ? 1 : (m_words > MAX_WORDS) ? MAX_WORDS : m_words;
		blk = ADDR_W'(r.word_addr / wpb);
		base = int'(blk % sets) * MAX_WAYS;
		o = '0;
		v = 0;
		for (int w = 0; w < ways; w++)
			if (!o.hit && m_valid[base+w] && m_block[base+w] == blk) begin
				o.hit = 1'b1; v = w;
			end
		if (o.hit) begin
			idx = base + v;
			m_cycles = add_cyc(m_cycles, COST_HIT);
			m_stamp[idx] = m_cycles;
			if (r.func) m_dirty[idx] = 1'b1;
			o.access_cycles = COST_HIT;
		end else begin
			m_misses = bump(m_misses);
			if (!r.func) m_rd_misses = bump(m_rd_misses);
			m_cycles = add_cyc(m_cycles, COST_MEM);
			o.access_cycles = COST_MEM + COST_FILL;
			if (m_lru) begin
				for (int w = 1; w < ways; w++)
					if (m_stamp[base+w] < m_stamp[base+v]) v = w;
			end else begin
				lsb = m_lfsr[0];
				m_lfsr = m_lfsr >> 1;
				if (lsb) m_lfsr = m_lfsr ^ LFSR_TAPS;
				v = m_lfsr % ways;
			end
			idx = base + v;
			o.evict_valid = m_valid[idx];
			if (o.evict_valid) o.evicted_block = m_block[idx];
			o.evict_dirty = m_valid[idx] && m_dirty[idx];
			if (o.evict_dirty) begin
				m_cycles = add_cyc(m_cycles, COST_MEM);
				m_dirty_ev = bump(m_dirty_ev);
				o.access_cycles += COST_MEM;
			end
			m_valid[idx] = 1'b1; m_block[idx] = blk; m_dirty[idx] = r.func;
			m_stamp[idx] = m_cycles;
			m_cycles = add_cyc(m_cycles, COST_FILL);
		end
		o.way = v[WAY_W-1:0];
		o.total_cycles = m_cycles;
		o.total_misses = m_misses;
		o.read_misses = m_rd_misses;
		o.dirty_evictions = m_dirty_ev;
		return o;
	endfunction

	task automatic cmp(string name, logic [CYC_W-1:0] exp_v, logic [CYC_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t e;
		if (done) begin
			if (pending_rsp.size() == 0) begin
				$error("result with no request outstanding");
				failures++;
			end else begin
				e = pending_rsp.pop_front();
				cmp("hit", e.hit, result.hit);
				cmp("way", e.way, result.way);
				cmp("evict_valid", e.evict_valid, result.evict_valid);
				cmp("evict_dirty", e.evict_dirty, result.evict_dirty);
				cmp("evicted_block", e.evicted_block, result.evicted_block);
				cmp("access_cycles", e.access_cycles, result.access_cycles);
				cmp("total_cycles", e.total_cycles, result.total_cycles);
				cmp("total_misses", e.total_misses, result.total_misses);
				cmp("read_misses", e.read_misses, result.read_misses);
				cmp("dirty_evictions", e.dirty_evictions, result.dirty_evictions);
			end
		end
		if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	int gap_left = 0;

	task automatic send(req_t r);
		rsp_t e;
		@(posedge clk);
		if (gap_left == 0) begin
			gap_left = $urandom_range(1, 8);
			repeat ($urandom_range(0, 40)) @(posedge clk);
		end
		gap_left--;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		e = cache_access(r);
		pending_rsp.push_back(e);
		start <= 1'b0;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_config(idx, d);
	endtask

	task automatic set_cfg(int w, int s, int b, int l);
		write_reg(CFG_WAYS, CFG_DAT_W'(w));
		write_reg(CFG_SETS, CFG_DAT_W'(s));
		write_reg(CFG_WORDS, CFG_DAT_W'(b));
		write_reg(CFG_LRU, CFG_DAT_W'(l));
	endtask

	typedef struct {
		logic func;
		logic [ADDR_W-1:0] addr;
		logic fixed;
		logic hit;
		logic [ACC_W-1:0] acc;
	} row_stim_t;

	row_stim_t directed[] = '{
		'{1'b0, 31'd0, 1'b1, 1'b0, 7'd65},
		'{1'b0, 31'd1, 1'b1, 1'b1, 7'd5},
		'{1'b1, 31'd0, 1'b1, 1'b1, 7'd5},
		'{1'b0, 31'h7FFFFFFF, 1'b1, 1'b0, 7'd65},
		'{1'b1, 31'd4096, 1'b0, 1'b0, 7'd0},
		'{1'b0, 31'd8192, 1'b0, 1'b0, 7'd0},
		'{1'b0, 31'd12288, 1'b0, 1'b0, 7'd0},
		'{1'b1, 31'd0, 1'b0, 1'b0, 7'd0},
		'{1'b1, 31'h7FFFFFFE, 1'b0, 1'b0, 7'd0},
		'{1'b0, 31'h40000000, 1'b0, 1'b0, 7'd0}
	};

	task automatic random_phase(int n, int span);
		req_t r;
		for (int i = 0; i < n; i++) begin
			r.func = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 9) == 0) r.word_addr = ADDR_W'($urandom() >> 1);
			else r.word_addr = ADDR_W'($urandom_range(0, span));
			send(r);
		end
	endtask

	initial begin
		rsp_t e;
		shadow_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[k]) begin
			send('{func: directed[k].func, word_addr: directed[k].addr});
			e = pending_rsp[$];
			if (directed[k].fixed && (e.hit !== directed[k].hit
					|| e.access_cycles !== directed[k].acc)) begin
				$error("table row %0d: predictor disagrees", k);
				failures++;
			end
		end
		write_reg(CFG_NONE, 13'h1FFF);
		set_cfg(0, 0, 0, 0);
		random_phase(30, 20);
		set_cfg(4, 4096, 16, 1);
		random_phase(60, 200000);
		set_cfg(7, 13'h1FFF, 31, 0);
		random_phase(40, 300);
		set_cfg(3, 5, 3, 1);
		random_phase(120, 200);
		set_cfg(4, 2, 1, 0);
		random_phase(120, 60);
		set_cfg(1, 1, 1, 1);
		random_phase(40, 8);
		set_cfg(4, 3, 5, 1);
		random_phase(110, 0);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (failures == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
